FILE: design/utf8_stream_decoder_top_macros.svh
// ----------------------------------------------------------------------------
// utf8 stream decoder assertion macros
// Shared concurrent assertion forms for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// implication checked at every clock edge outside reset
`define UTF8SD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("utf8 decoder assertion failed");

// implication whose consequence is checked at the next clock edge
`define UTF8SD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("utf8 decoder assertion failed");

`endif

FILE: design/utf8sd_pkg.sv
// ----------------------------------------------------------------------------
// utf8sd_pkg
// Shared constants and controller/datapath interface types of the decoder.
// ----------------------------------------------------------------------------
package utf8sd_pkg;

  localparam int unsigned CpW      = 21;
  localparam int unsigned CntW     = 3;
  localparam int unsigned InDataW  = 8;
  localparam int unsigned OutDataW = 24;

  localparam logic [CpW-1:0] CpRepl = 21'h00FFFD;
  localparam logic [CpW-1:0] CpMax  = 21'h10FFFF;
  localparam logic [CpW-1:0] SurLo  = 21'h00D800;
  localparam logic [CpW-1:0] SurHi  = 21'h00DFFF;
  localparam logic [CpW-1:0] Min2   = 21'h000080;
  localparam logic [CpW-1:0] Min3   = 21'h000800;
  localparam logic [CpW-1:0] Min4   = 21'h010000;

  // commands from controller to datapath
  typedef struct packed {
    logic accept;     // input transaction taken this cycle
    logic pop;        // load next result into output register
    logic pop_final;  // the popped result is the last of its byte
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic [CntW-1:0] n_results;  // results caused by the byte on the input
  } dp_stat_t;

endpackage

FILE: design/utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// utf8_stream_decoder_top
// Byte-serial UTF-8 decoder with U+FFFD replacement of rejected bytes.
// ----------------------------------------------------------------------------
// Input stream: one text byte per transaction on in_tdata. A zero byte ends
// the string: held bytes come out as U+FFFD and the decoder returns to idle.
// Output stream: one decoded code point per transaction; out_tuser flags a
// replacement, out_tlast marks the final result caused by one input byte.
// A byte may cause no result (lead or middle byte of a form, or a zero byte
// with nothing held) or up to four results (a rejected four-byte form).
// Timing: a byte taken is recorded in the sequence state and pending result
// registers; its results then pass through the output register in order.
// Throughput: one byte per cycle while each byte gives at most one result and
// the receiver keeps up; a byte with more results holds in_tready low until
// its last result is popped into the single output register, which drains
// one result per cycle while the receiver accepts.
// Reset (rst_n low, synchronous) drops any held sequence and empties the
// output register. When the receiver stalls, the output register holds its
// result and in_tready falls once the results of the current byte are owed.
// ----------------------------------------------------------------------------
module utf8_stream_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,    // [7:0] in_byte
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,   // [20:0] code_point, [23:21] byte_count
  output logic        out_tuser,   // [0] invalid
  output logic        out_tlast    // last result of the input byte
);

  utf8sd_pkg::dp_cmd_t                cmd;
  utf8sd_pkg::dp_stat_t               stat;
  logic [utf8sd_pkg::CpW-1:0]         out_cp;
  logic [utf8sd_pkg::CntW-1:0]        out_cnt;

  // handshake controller
  utf8sd_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  // decode datapath
  utf8sd_dp u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_byte  (in_tdata),
    .cmd      (cmd),
    .stat     (stat),
    .out_cp   (out_cp),
    .out_inv  (out_tuser),
    .out_cnt  (out_cnt),
    .out_last (out_tlast)
  );

  assign out_tdata = {out_cnt, out_cp};

endmodule

FILE: design/utf8sd_ctrl.sv
// ----------------------------------------------------------------------------
// utf8sd_ctrl
// Handshake controller: tracks results still owed and the output register.
// ----------------------------------------------------------------------------
module utf8sd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  input  utf8sd_pkg::dp_stat_t stat,
  output utf8sd_pkg::dp_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EMIT = 2'b10
  } state_t;

  state_t                      state_r, state_nxt;
  logic [utf8sd_pkg::CntW-1:0] rem_r, rem_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        pop;
  logic                        accept;

  // in S_EMIT, pop a result whenever the output register is free or being drained
  always_comb begin
    unique case (state_r)
      S_IDLE: begin
        pop       = 1'b0;
        in_tready = 1'b1;
      end
      S_EMIT: begin
        pop       = !out_valid_r || out_tready;
        in_tready = pop && (rem_r == utf8sd_pkg::CntW'(1));
      end
      default: begin
        pop       = 1'b0;
        in_tready = 1'b0;
      end
    endcase
  end

  assign accept = in_tvalid && in_tready;

  // remaining result count and state
  always_comb begin
    rem_nxt = rem_r;
    if (accept) begin
      rem_nxt = stat.n_results;
    end else if (pop) begin
      rem_nxt = rem_r - utf8sd_pkg::CntW'(1);
    end
    state_nxt = (rem_nxt != '0) ? S_EMIT : S_IDLE;
  end

  // output register occupancy
  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      rem_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      rem_r       <= rem_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid    = out_valid_r;
  assign cmd.accept    = accept;
  assign cmd.pop       = pop;
  assign cmd.pop_final = (rem_r == utf8sd_pkg::CntW'(1));

endmodule

FILE: design/utf8sd_dp.sv
// ----------------------------------------------------------------------------
// utf8sd_dp
// Decoder datapath: held sequence bytes, byte classification, code point
// assembly and range checks, pending final result and output register.
// ----------------------------------------------------------------------------
module utf8sd_dp (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic [7:0]                     in_byte,
  input  utf8sd_pkg::dp_cmd_t            cmd,
  output utf8sd_pkg::dp_stat_t           stat,
  output logic [utf8sd_pkg::CpW-1:0]     out_cp,
  output logic                           out_inv,
  output logic [utf8sd_pkg::CntW-1:0]    out_cnt,
  output logic                           out_last
);

  localparam int unsigned CpW  = utf8sd_pkg::CpW;
  localparam int unsigned CntW = utf8sd_pkg::CntW;

  // sequence state
  logic [7:0]      held0_r, held1_r, held2_r;
  logic [CntW-1:0] held_cnt_r, held_cnt_nxt;
  logic [CntW-1:0] need_r, need_nxt;

  // final result of the current byte, emitted after any replacements
  logic            tail_r, tail_nxt;
  logic [CpW-1:0]  tail_cp_r, tail_cp_nxt;
  logic            tail_inv_r, tail_inv_nxt;
  logic [CntW-1:0] tail_cnt_r, tail_cnt_nxt;

  // output register
  logic [CpW-1:0]  out_cp_r;
  logic            out_inv_r;
  logic [CntW-1:0] out_cnt_r;
  logic            out_last_r;

  logic            pending, is_cont, complete, cp_ok;
  logic            f_zero, f_ascii, f_bad;
  logic [CntW-1:0] f_len, rep_n;
  logic [CpW-1:0]  cp_full;
  logic            wr_held0, wr_held1, wr_held2;

  // classify the incoming byte as a fresh item
  always_comb begin
    f_zero  = (in_byte == 8'h00);
    f_ascii = !in_byte[7] && !f_zero;
    if (in_byte[7:5] == 3'b110) begin
      f_len = CntW'(2);
    end else if (in_byte[7:4] == 4'b1110) begin
      f_len = CntW'(3);
    end else if (in_byte[7:3] == 5'b11110) begin
      f_len = CntW'(4);
    end else begin
      f_len = '0;
    end
    f_bad = in_byte[7] && (f_len == '0);
  end

  assign pending  = (held_cnt_r != '0);
  assign is_cont  = (in_byte[7:6] == 2'b10);
  assign complete = (held_cnt_r + CntW'(1)) == need_r;

  // code point assembly with the incoming byte as the final one
  always_comb begin
    unique case (need_r)
      CntW'(2): begin
        cp_full = {10'b0, held0_r[4:0], in_byte[5:0]};
        cp_ok   = (cp_full >= utf8sd_pkg::Min2);
      end
      CntW'(3): begin
        cp_full = {5'b0, held0_r[3:0], held1_r[5:0], in_byte[5:0]};
        cp_ok   = (cp_full >= utf8sd_pkg::Min3) &&
                  !((cp_full >= utf8sd_pkg::SurLo) && (cp_full <= utf8sd_pkg::SurHi));
      end
      CntW'(4): begin
        cp_full = {held0_r[2:0], held1_r[5:0], held2_r[5:0], in_byte[5:0]};
        cp_ok   = (cp_full >= utf8sd_pkg::Min4) && (cp_full <= utf8sd_pkg::CpMax);
      end
      default: begin
        cp_full = '0;
        cp_ok   = 1'b0;
      end
    endcase
  end

  // next sequence state and results of the incoming byte
  always_comb begin
    held_cnt_nxt = held_cnt_r;
    need_nxt     = need_r;
    rep_n        = '0;
    tail_nxt     = 1'b0;
    tail_cp_nxt  = utf8sd_pkg::CpRepl;
    tail_inv_nxt = 1'b1;
    tail_cnt_nxt = CntW'(1);
    wr_held0     = 1'b0;
    wr_held1     = 1'b0;
    wr_held2     = 1'b0;
    if (pending && is_cont) begin
      if (complete) begin
        held_cnt_nxt = '0;
        need_nxt     = '0;
        if (cp_ok) begin
          tail_nxt     = 1'b1;
          tail_cp_nxt  = cp_full;
          tail_inv_nxt = 1'b0;
          tail_cnt_nxt = need_r;
        end else begin
          rep_n = need_r;
        end
      end else begin
        held_cnt_nxt = held_cnt_r + CntW'(1);
        wr_held1     = (held_cnt_r == CntW'(1));
        wr_held2     = (held_cnt_r == CntW'(2));
      end
    end else begin
      // broken sequence flushes every held byte, then the byte starts fresh
      rep_n        = held_cnt_r;
      held_cnt_nxt = '0;
      need_nxt     = '0;
      if (f_len != '0) begin
        held_cnt_nxt = CntW'(1);
        need_nxt     = f_len;
        wr_held0     = 1'b1;
      end else if (f_ascii) begin
        tail_nxt     = 1'b1;
        tail_cp_nxt  = CpW'(in_byte);
        tail_inv_nxt = 1'b0;
      end else if (f_bad) begin
        tail_nxt = 1'b1;
      end
    end
  end

  assign stat.n_results = rep_n + CntW'(tail_nxt);

  // held bytes carry no reset, each is written before it is read
  always_ff @(posedge clk) begin
    if (cmd.accept && wr_held0) begin
      held0_r <= in_byte;
    end
    if (cmd.accept && wr_held1) begin
      held1_r <= in_byte;
    end
    if (cmd.accept && wr_held2) begin
      held2_r <= in_byte;
    end
  end

  // sequence control state and pending final result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= '0;
      need_r     <= '0;
      tail_r     <= 1'b0;
    end else if (cmd.accept) begin
      held_cnt_r <= held_cnt_nxt;
      need_r     <= need_nxt;
      tail_r     <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      tail_cp_r  <= tail_cp_nxt;
      tail_inv_r <= tail_inv_nxt;
      tail_cnt_r <= tail_cnt_nxt;
    end
  end

  // output register: replacements first, then the final result
  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      out_last_r <= cmd.pop_final;
      if (cmd.pop_final && tail_r) begin
        out_cp_r  <= tail_cp_r;
        out_inv_r <= tail_inv_r;
        out_cnt_r <= tail_cnt_r;
      end else begin
        out_cp_r  <= utf8sd_pkg::CpRepl;
        out_inv_r <= 1'b1;
        out_cnt_r <= CntW'(1);
      end
    end
  end

  assign out_cp   = out_cp_r;
  assign out_inv  = out_inv_r;
  assign out_cnt  = out_cnt_r;
  assign out_last = out_last_r;

endmodule

FILE: design/utf8sd_checker.sv
// ----------------------------------------------------------------------------
// utf8sd_checker
// Port-level checks of the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`include "utf8_stream_decoder_top_macros.svh"

module utf8sd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [23:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // a stalled result holds
  `UTF8SD_ASSERT_NEXT(a_out_hold, clk, rst_n,
    out_tvalid && !out_tready,
    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

  // while a burst is stalled mid-way no new byte is taken
  `UTF8SD_ASSERT_IMP(a_no_take_mid_burst, clk, rst_n,
    in_tvalid && out_tvalid && !out_tlast && !out_tready, !in_tready)

  // replacements are U+FFFD covering one byte
  `UTF8SD_ASSERT_IMP(a_repl_form, clk, rst_n, out_tvalid && out_tuser,
    (out_tdata[20:0] == utf8sd_pkg::CpRepl) && (out_tdata[23:21] == 3'd1))

  // decoded values are scalar values with a byte count of one to four
  `UTF8SD_ASSERT_IMP(a_scalar, clk, rst_n, out_tvalid && !out_tuser,
    (out_tdata[20:0] <= utf8sd_pkg::CpMax) &&
    !((out_tdata[20:0] >= utf8sd_pkg::SurLo) && (out_tdata[20:0] <= utf8sd_pkg::SurHi)) &&
    (out_tdata[23:21] != 3'd0) && (out_tdata[23:21] <= 3'd4))

endmodule

bind utf8_stream_decoder_top utf8sd_checker u_utf8sd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);

FILE: dv/tb_utf8_stream_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_utf8_stream_decoder_top
// Self-checking bench for the byte-serial UTF-8 decoder. Text bytes go in on
// the input stream, and each byte taken updates a decoder model in the
// scoreboard. Each result taken is checked in order against the code point,
// replacement flag, byte count and last flag that the model expects. Stimulus
// is a directed set of edge cases followed by random text. The random text is
// mostly valid, with some malformed forms, truncated forms, raw noise and
// string terminators. Both sides idle at random, and one long receiver hold
// backs the decoder up until it stalls its input.
// ----------------------------------------------------------------------------
module tb_utf8_stream_decoder_top;

  // one decoded result as seen on the output stream
  typedef struct packed {
    logic [utf8sd_pkg::CpW-1:0]  cp;
    logic                        repl;
    logic [utf8sd_pkg::CntW-1:0] n_bytes;
    logic                        last;
  } cp_result_t;

  // decoder model and in-order result checker
  class utf8_scoreboard;
    logic [7:0]   held [4];
    int unsigned  held_n;
    int unsigned  need_n;
    cp_result_t   owed_cps [$];
    cp_result_t   burst [$];
    int unsigned  err_count;

    function new();
      held_n    = 0;
      need_n    = 0;
      err_count = 0;
    endfunction

    task report(string msg);
      $display("%0t: mismatch: %s", $time, msg);
      err_count++;
    endtask

    function void add_result(logic [utf8sd_pkg::CpW-1:0] cp, logic repl,
                             logic [utf8sd_pkg::CntW-1:0] n_bytes);
      cp_result_t r;
      r.cp      = cp;
      r.repl    = repl;
      r.n_bytes = n_bytes;
      r.last    = 1'b0;
      burst.push_back(r);
    endfunction

    // a byte seen while idle: ascii, a lead to hold, or a lone replacement
    function void scan_lead(logic [7:0] b);
      casez (b)
        8'b0???????: add_result(utf8sd_pkg::CpW'(b), 1'b0, utf8sd_pkg::CntW'(1));
        8'b110?????: begin held[0] = b; held_n = 1; need_n = 2; end
        8'b1110????: begin held[0] = b; held_n = 1; need_n = 3; end
        8'b11110???: begin held[0] = b; held_n = 1; need_n = 4; end
        default:     add_result(utf8sd_pkg::CpRepl, 1'b1, utf8sd_pkg::CntW'(1));
      endcase
    endfunction

    // every held byte turns into a replacement
    function void flush_held();
      for (int unsigned i = 0; i < held_n; i++)
        add_result(utf8sd_pkg::CpRepl, 1'b1, utf8sd_pkg::CntW'(1));
      held_n = 0;
      need_n = 0;
    endfunction

    // full form collected: build the code point and range check it
    function void decode_held();
      logic [utf8sd_pkg::CpW-1:0] cp;
      logic                       ok;
      case (need_n)
        2: begin
          cp = utf8sd_pkg::CpW'({held[0][4:0], held[1][5:0]});
          ok = cp >= utf8sd_pkg::Min2;
        end
        3: begin
          cp = utf8sd_pkg::CpW'({held[0][3:0], held[1][5:0], held[2][5:0]});
          ok = cp >= utf8sd_pkg::Min3 &&
               !(cp >= utf8sd_pkg::SurLo && cp <= utf8sd_pkg::SurHi);
        end
        default: begin
          cp = {held[0][2:0], held[1][5:0], held[2][5:0], held[3][5:0]};
          ok = cp >= utf8sd_pkg::Min4 && cp <= utf8sd_pkg::CpMax;
        end
      endcase
      if (ok) begin
        add_result(cp, 1'b0, utf8sd_pkg::CntW'(need_n));
        held_n = 0;
        need_n = 0;
      end else begin
        flush_held();
      end
    endfunction

    // input transaction taken: work out the results it owes
    function void note_byte(logic [7:0] b);
      burst.delete();
      if (held_n == 0) begin
        if (b != 8'h00) scan_lead(b);
      end else if (b[7:6] == 2'b10) begin
        held[held_n] = b;
        held_n++;
        if (held_n == need_n) decode_held();
      end else begin
        flush_held();
        if (b != 8'h00) scan_lead(b);
      end
      if (burst.size() != 0) burst[burst.size()-1].last = 1'b1;
      foreach (burst[i]) owed_cps.push_back(burst[i]);
    endfunction

    // output transaction taken: compare with the oldest owed result
    task check_result(cp_result_t got);
      cp_result_t want;
      if (owed_cps.size() == 0) begin
        report($sformatf("unexpected result cp %0h", got.cp));
        return;
      end
      want = owed_cps.pop_front();
      if (got.cp != want.cp)
        report($sformatf("code point %0h, expected %0h", got.cp, want.cp));
      if (got.repl != want.repl)
        report($sformatf("invalid flag %0b, expected %0b", got.repl, want.repl));
      if (got.n_bytes != want.n_bytes)
        report($sformatf("byte count %0d, expected %0d", got.n_bytes, want.n_bytes));
      if (got.last != want.last)
        report($sformatf("last flag %0b, expected %0b", got.last, want.last));
    endtask
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [7:0]  in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  utf8_scoreboard tracker = new();
  bit             calm = 1'b0;
  int unsigned    hold_req = 0;

  utf8_stream_decoder_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // idle cycles before one transaction, none during calm stretches
  function automatic int unsigned draw_gap();
    return calm ? 0 : $urandom_range(0, 14);
  endfunction

  // offer one byte and wait for it to be taken
  task automatic send_byte(input logic [7:0] b);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    do @(posedge clk); while (!in_tready);
    tracker.note_byte(b);
  endtask

  // random text: mostly valid forms, then malformed, truncated, noise, zero
  task automatic send_random_text(input int unsigned n_bytes);
    int unsigned sent;
    int unsigned pick;
    int unsigned len;
    logic [20:0] cp;
    logic [7:0]  form [4];
    sent = 0;
    while (sent < n_bytes) begin
      pick = $urandom_range(0, 19);
      len  = $urandom_range(2, 4);
      if (pick < 12) begin
        len = $urandom_range(1, 4);
        case (len)
          1: begin
            cp = 21'($urandom_range(1, 'h7F));
            form[0] = cp[7:0];
          end
          2: begin
            cp = 21'($urandom_range('h80, 'h7FF));
            form[0] = {3'b110, cp[10:6]};
            form[1] = {2'b10, cp[5:0]};
          end
          3: begin
            cp = 21'($urandom_range('h800, 'hFFFF));
            form[0] = {4'b1110, cp[15:12]};
            form[1] = {2'b10, cp[11:6]};
            form[2] = {2'b10, cp[5:0]};
          end
          default: begin
            cp = 21'($urandom_range('h10000, 'h10FFFF));
            form[0] = {5'b11110, cp[20:18]};
            form[1] = {2'b10, cp[17:12]};
            form[2] = {2'b10, cp[11:6]};
            form[3] = {2'b10, cp[5:0]};
          end
        endcase
      end else if (pick < 18) begin
        // any lead of its class, any continuations; cut short on some
        case (len)
          2:       form[0] = {3'b110, 5'($urandom)};
          3:       form[0] = {4'b1110, 4'($urandom)};
          default: form[0] = {5'b11110, 3'($urandom)};
        endcase
        for (int k = 1; k < 4; k++) form[k] = {2'b10, 6'($urandom)};
        if (pick >= 16) len = $urandom_range(1, len - 1);
      end else if (pick == 18) begin
        len = 1;
        form[0] = 8'($urandom_range(0, 255));
      end else begin
        len = 1;
        form[0] = 8'h00;
      end
      for (int k = 0; k < len; k++) send_byte(form[k]);
      sent += len;
    end
  endtask

  // receiver: random stall per result, plus a long hold on request
  initial begin
    int unsigned stall;
    int unsigned held_cycles;
    out_tready = 1'b0;
    @(posedge rst_n);
    forever begin
      if (hold_req != 0) begin
        held_cycles = hold_req;
        hold_req    = 0;
        @(negedge clk);
        out_tready <= 1'b0;
        repeat (held_cycles) @(negedge clk);
      end
      stall = draw_gap();
      @(negedge clk);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  // output monitor
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.check_result({out_tdata[20:0], out_tuser, out_tdata[23:21], out_tlast});
  end

  // stimulus and end of run
  initial begin
    logic [7:0] directed [$];
    in_tvalid = 1'b0;
    in_tdata  = 8'h00;
    rst_n     = 1'b0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // zero with nothing held, ascii letter and upper limit, stray continuation, never-lead byte
    directed = '{8'h00, 8'h41, 8'h7F, 8'h80, 8'hFF,
                 // two-byte form, highest scalar value
                 8'hC3, 8'hA9, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
                 // overlong, surrogate, above the scalar range
                 8'hC0, 8'h80, 8'hED, 8'hA0, 8'h80, 8'hF4, 8'h90, 8'h80, 8'h80,
                 // form broken by ascii, form cut by the terminator
                 8'hE2, 8'h41, 8'hF0, 8'h9F, 8'h00};
    foreach (directed[i]) send_byte(directed[i]);

    send_random_text(70);
    calm     = 1'b1;
    hold_req = 60;
    send_random_text(40);
    calm = 1'b0;
    send_random_text(85);

    @(negedge clk);
    in_tvalid <= 1'b0;
    while (tracker.owed_cps.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (tracker.err_count == 0)
      $display("[utf8_stream_decoder_top] OK");
    else
      $display("[utf8_stream_decoder_top] ERROR");
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("[utf8_stream_decoder_top] ERROR");
    $finish;
  end

endmodule
